[design/bounded_queue_running_mean_core_defines.svh]
// Assertion macros shared by the queue core.
// Define ASSERT_OFF to compile all assertions away.
`ifndef BOUNDED_QUEUE_RUNNING_MEAN_CORE_DEFINES_SVH
`define BOUNDED_QUEUE_RUNNING_MEAN_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// A property that must hold at every clock edge outside reset.
`define BQRM_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) \
		else $error("bqrm assertion failed");

// A condition that must be followed by a consequence in the next cycle.
`define BQRM_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("bqrm assertion failed");

`else

`define BQRM_ASSERT(lbl, ck, rstn, prop)
`define BQRM_ASSERT_NEXT(lbl, ck, rstn, ante, cons)

`endif

`endif

[design/bqrm_pkg.sv]
package bqrm_pkg;

	localparam int DEFAULT_CAPACITY = 5;

	localparam int ID_W   = 10;
	localparam int RATE_W = 8;
	localparam int MEAN_W = 8;
	localparam int OCC_W  = 3;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [RATE_W-1:0] rate;
	} bqrm_entry_t;

	// Per-cell control: load takes the new entry, shift takes the neighbor's.
	typedef struct packed {
		logic shift;
		logic load;
	} bqrm_cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_HOLD
	} bqrm_state_t;

endpackage

[design/bounded_queue_running_mean_core.sv]
// Channel   Direction  Handshake             Payload
// cmd       in         cmd_valid/cmd_stall   action, item_id, rate
// res       out        res_valid/res_stall   mean_rate, removed_id, removed_rate,
//                                            empty_error, occupancy
//
// An insert goes from one cmd transfer to the next through accept, the
// bit-serial divider that forms the rounded mean, the hand-over to the res
// register once it is free, and back to idle.
// A remove, or a remove on an empty queue, skips the divider.
// arst_n clears the count, the sum, the control state and the res valid flag;
// the entry cells hold no reset value and are only read once written.
// A stall on res holds the finished result in the res register; the next cmd
// transfer is still taken, and its result waits until the register drains.
`include "bounded_queue_running_mean_core_defines.svh"

module bounded_queue_running_mean_core #(
	parameter int CAPACITY = bqrm_pkg::DEFAULT_CAPACITY
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  logic                        action,
	input  logic [bqrm_pkg::ID_W-1:0]   item_id,
	input  logic [bqrm_pkg::RATE_W-1:0] rate,

	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [bqrm_pkg::MEAN_W-1:0] mean_rate,
	output logic [bqrm_pkg::ID_W-1:0]   removed_id,
	output logic [bqrm_pkg::RATE_W-1:0] removed_rate,
	output logic                        empty_error,
	output logic [bqrm_pkg::OCC_W-1:0]  occupancy
);
	import bqrm_pkg::*;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int SUM_W  = CNT_W + RATE_W;
	localparam int DIVD_W = SUM_W + 1;

	bqrm_state_t state_q, state_d;

	logic [CNT_W-1:0] count_q, count_d;
	logic [SUM_W-1:0] sum_q, sum_d;

	logic accept;
	logic is_full;
	logic is_empty;
	logic do_insert;
	logic do_remove;
	logic do_error;
	logic out_load;

	// The queue is a row of cells with the oldest entry in cell zero.
	// A remove, or an insert into a full queue, moves every entry one cell
	// toward the head; an insert writes the new entry at the tail.
	bqrm_entry_t    new_entry;
	bqrm_entry_t    head;
	bqrm_entry_t    cell_entry [CAPACITY];
	bqrm_entry_t    cell_next  [CAPACITY];
	bqrm_cell_ctl_t cell_ctl   [CAPACITY];

	logic [DIVD_W-1:0] div_dividend;
	logic [CNT_W:0]    div_divisor;
	logic              div_done;
	logic [MEAN_W-1:0] div_quotient;

	// Result being assembled while the divider runs.
	logic [MEAN_W-1:0] pend_mean_q;
	logic [ID_W-1:0]   pend_id_q;
	logic [RATE_W-1:0] pend_rate_q;
	logic              pend_err_q;
	logic [OCC_W-1:0]  pend_occ_q;

	// Output register that parts the two channels.
	logic              res_valid_q;
	logic [MEAN_W-1:0] mean_q;
	logic [ID_W-1:0]   removed_id_q;
	logic [RATE_W-1:0] removed_rate_q;
	logic              empty_error_q;
	logic [OCC_W-1:0]  occ_q;

	assign accept    = cmd_valid && !cmd_stall;
	assign is_full   = count_q == CNT_W'(CAPACITY);
	assign is_empty  = count_q == '0;
	assign do_insert = accept && (action == ACT_INSERT);
	assign do_remove = accept && (action == ACT_REMOVE) && !is_empty;
	assign do_error  = accept && (action == ACT_REMOVE) && is_empty;

	assign new_entry = '{id: item_id, rate: rate};
	assign head      = cell_entry[0];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == CAPACITY - 1) begin : g_tail
			assign cell_next[i] = new_entry;
		end else begin : g_body
			assign cell_next[i] = cell_entry[i+1];
		end

		assign cell_ctl[i].shift = do_remove || (do_insert && is_full);
		assign cell_ctl[i].load  = do_insert &&
			(is_full ? (i == CAPACITY - 1) : (count_q == CNT_W'(i)));

		bqrm_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.new_entry  (new_entry),
			.next_entry (cell_next[i]),
			.entry      (cell_entry[i])
		);
	end

	// Running count and sum. An insert into a full queue drops the head's
	// rate from the sum while the count stays at capacity.
	always_comb begin
		count_d = count_q;
		sum_d   = sum_q;
		if (do_insert) begin
			if (is_full) begin
				sum_d = sum_q - SUM_W'(head.rate) + SUM_W'(rate);
			end else begin
				count_d = count_q + 1'b1;
				sum_d   = sum_q + SUM_W'(rate);
			end
		end else if (do_remove) begin
			count_d = count_q - 1'b1;
			sum_d   = sum_q - SUM_W'(head.rate);
		end
	end

	// Rounded-half-up mean: (2*sum + count) / (2*count).
	assign div_dividend = {sum_d, 1'b0} + DIVD_W'(count_d);
	assign div_divisor  = {count_d, 1'b0};

	bqrm_div #(
		.CAPACITY (CAPACITY)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (do_insert),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (action == ACT_INSERT) ? ST_DIVIDE : ST_HOLD;
				end
			end
			ST_DIVIDE: begin
				if (div_done) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		cmd_stall = state_q != ST_IDLE;
		out_load  = (state_q == ST_HOLD) && (!res_valid_q || !res_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Pending result fields. A remove reports the head as it was before the
	// transfer; the mean arrives later from the divider on an insert.
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_mean_q <= '0;
			pend_id_q   <= do_remove ? head.id : '0;
			pend_rate_q <= do_remove ? head.rate : '0;
			pend_err_q  <= do_error;
			pend_occ_q  <= OCC_W'(count_d);
		end else if (div_done) begin
			pend_mean_q <= div_quotient;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mean_q         <= pend_mean_q;
			removed_id_q   <= pend_id_q;
			removed_rate_q <= pend_rate_q;
			empty_error_q  <= pend_err_q;
			occ_q          <= pend_occ_q;
		end
	end

	assign res_valid    = res_valid_q;
	assign mean_rate    = mean_q;
	assign removed_id   = removed_id_q;
	assign removed_rate = removed_rate_q;
	assign empty_error  = empty_error_q;
	assign occupancy    = occ_q;

	// The count never passes capacity, and an empty queue carries no sum.
	`BQRM_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(CAPACITY))
	`BQRM_ASSERT(a_empty_sum, clk, arst_n, (count_q != '0) || (sum_q == '0))
	// The divider only finishes while the sequencer waits for it.
	`BQRM_ASSERT(a_done_in_divide, clk, arst_n, !div_done || (state_q == ST_DIVIDE))
	`BQRM_ASSERT_NEXT(a_load_shows, clk, arst_n, out_load, res_valid_q)
	// A remove on an empty queue reports nothing but the flag.
	`BQRM_ASSERT(a_error_clean, clk, arst_n, !(res_valid_q && empty_error_q) ||
		((mean_q == '0) && (removed_id_q == '0) && (occ_q == '0)))

endmodule

[design/bqrm_cell.sv]
module bqrm_cell (
	input  logic                   clk,
	input  bqrm_pkg::bqrm_cell_ctl_t ctl,
	input  bqrm_pkg::bqrm_entry_t  new_entry,
	input  bqrm_pkg::bqrm_entry_t  next_entry,
	output bqrm_pkg::bqrm_entry_t  entry
);
	import bqrm_pkg::*;

	bqrm_entry_t entry_q;

	// A load wins over a shift: the tail cell of a full queue does both.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= new_entry;
		end else if (ctl.shift) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

[design/bqrm_div.sv]
module bqrm_div #(
	parameter  int CAPACITY = bqrm_pkg::DEFAULT_CAPACITY,
	localparam int CNT_W    = $clog2(CAPACITY + 1),
	localparam int DIVD_W   = CNT_W + bqrm_pkg::RATE_W + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DIVD_W-1:0]           dividend,
	input  logic [CNT_W:0]              divisor,
	output logic                        done,
	output logic [bqrm_pkg::MEAN_W-1:0] quotient
);
	import bqrm_pkg::*;

	localparam int STEP_W = (MEAN_W > 1) ? $clog2(MEAN_W) : 1;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIVD_W-1:0] rem_q;
	logic [DIVD_W-1:0] dsh_q;
	logic [MEAN_W-1:0] quo_q;
	logic              fits;

	// The quotient is known to fit in MEAN_W bits, so the divisor starts
	// shifted by MEAN_W-1 and one quotient bit is resolved per cycle.
	assign fits = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			dsh_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= dividend;
				dsh_q  <= DIVD_W'(divisor) << (MEAN_W - 1);
				quo_q  <= '0;
				step_q <= STEP_W'(MEAN_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (fits) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[MEAN_W-2:0], fits};
				dsh_q <= dsh_q >> 1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[dv/bounded_queue_running_mean_core_test.sv]
`timescale 1ns / 100ps

module bounded_queue_running_mean_core_test;
	import bqrm_pkg::*;

	localparam int DEPTH       = DEFAULT_CAPACITY;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_OPS  = 500;
	localparam int SETTLE      = 20;

	// One command as the driver presents it. A set hold_for_drain bit makes the
	// driver wait until every outstanding result has been collected first.
	typedef struct {
		logic              act;
		logic [ID_W-1:0]   id;
		logic [RATE_W-1:0] rt;
		bit                hold_for_drain;
	} queue_cmd_t;

	// One result as the block reports it.
	typedef struct {
		logic [MEAN_W-1:0] mean;
		logic [ID_W-1:0]   rid;
		logic [RATE_W-1:0] rrate;
		logic              err;
		logic [OCC_W-1:0]  occ;
	} queue_outcome_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	logic              action = ACT_INSERT;
	logic [ID_W-1:0]   item_id = '0;
	logic [RATE_W-1:0] rate = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic [MEAN_W-1:0] mean_rate;
	logic [ID_W-1:0]   removed_id;
	logic [RATE_W-1:0] removed_rate;
	logic              empty_error;
	logic [OCC_W-1:0]  occupancy;

	bounded_queue_running_mean_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.action       (action),
		.item_id      (item_id),
		.rate         (rate),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.mean_rate    (mean_rate),
		.removed_id   (removed_id),
		.removed_rate (removed_rate),
		.empty_error  (empty_error),
		.occupancy    (occupancy)
	);

	// Commands waiting to be driven, and results the block still owes us.
	queue_cmd_t     cmd_backlog[$];
	queue_outcome_t owed_results[$];

	// The driver counts the commands it has put on the bus; the monitor counts
	// the transfers it has seen. While the two differ, the bus is holding a
	// command that the block has not taken yet.
	int unsigned issued     = 0;
	int unsigned accepted   = 0;
	int unsigned mismatches = 0;
	int unsigned cycles     = 0;
	int unsigned stall_left = 0;

	// Our own copy of the ring: slot contents, the oldest slot, the number of
	// live entries and the running sum of their rates.
	logic [ID_W-1:0]   ring_id[DEPTH];
	logic [RATE_W-1:0] ring_rate[DEPTH];
	int unsigned       ring_head  = 0;
	int unsigned       ring_count = 0;
	int unsigned       ring_sum   = 0;

	// A stretch of the run in which neither side idles, so that the block also
	// sees back-to-back traffic for a long while. It sits between two of the
	// commands that wait for a drain.
	wire steady_window = (issued >= 230) && (issued < 320);

	initial begin
		forever #5 clk = ~clk;
	end

	// Reset is held from time zero and released away from the rising edge.
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Applies one command to the ring copy and returns what the block must
	// report for it. An insert on a full ring silently drops the oldest entry
	// before appending; a remove on an empty ring only raises the error flag.
	function automatic queue_outcome_t advance_ring(queue_cmd_t c);
		queue_outcome_t r;
		int unsigned    slot;
		r = '{default: '0};
		if (c.act == ACT_INSERT) begin
			if (ring_count >= DEPTH) begin
				ring_sum   -= ring_rate[ring_head];
				ring_head   = (ring_head + 1) % DEPTH;
				ring_count -= 1;
			end
			slot            = (ring_head + ring_count) % DEPTH;
			ring_id[slot]   = c.id;
			ring_rate[slot] = c.rt;
			ring_sum       += c.rt;
			ring_count     += 1;
			// Mean rounded half up, kept in integer arithmetic.
			r.mean = MEAN_W'((2 * ring_sum + ring_count) / (2 * ring_count));
		end else if (ring_count == 0) begin
			r.err = 1'b1;
		end else begin
			r.rid       = ring_id[ring_head];
			r.rrate     = ring_rate[ring_head];
			ring_sum   -= ring_rate[ring_head];
			ring_head   = (ring_head + 1) % DEPTH;
			ring_count -= 1;
		end
		r.occ = OCC_W'(ring_count);
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	function automatic void queue_cmd(logic act, int id, int rt, bit hold = 1'b0);
		queue_cmd_t c;
		c.act            = act;
		c.id             = ID_W'(id);
		c.rt             = RATE_W'(rt);
		c.hold_for_drain = hold;
		cmd_backlog.push_back(c);
	endfunction

	// Field values lean toward the extremes now and then.
	function automatic int pick_value(int top);
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 0;
		if (roll == 1)
			return top;
		return $urandom_range(0, top);
	endfunction

	// Stimulus and end of run.
	initial begin
		int unsigned remove_pct;
		int unsigned max_id;
		int unsigned max_rate;
		max_id   = (1 << ID_W) - 1;
		max_rate = (1 << RATE_W) - 1;

		// Directed part. A remove on the empty queue comes first, then the
		// smallest and largest fields, where the second insert lands exactly on
		// a half and must round up.
		queue_cmd(ACT_REMOVE, $urandom, $urandom);
		queue_cmd(ACT_INSERT, 0, 0);
		queue_cmd(ACT_INSERT, max_id, max_rate);
		queue_cmd(ACT_REMOVE, $urandom, $urandom);
		queue_cmd(ACT_REMOVE, $urandom, $urandom);
		queue_cmd(ACT_REMOVE, $urandom, $urandom);
		// Fill to capacity with the largest rate, which gives the largest sum.
		queue_cmd(ACT_INSERT, max_id, max_rate);
		queue_cmd(ACT_INSERT, 10'h200, max_rate);
		queue_cmd(ACT_INSERT, 10'h155, max_rate);
		queue_cmd(ACT_INSERT, 10'h2AA, max_rate);
		queue_cmd(ACT_INSERT, 1, max_rate);
		// Two inserts on a full queue push out the oldest entries unreported.
		queue_cmd(ACT_INSERT, 10'h0F0, 0);
		queue_cmd(ACT_INSERT, 10'h30F, 1);
		// Drain completely and try once more past empty.
		repeat (6)
			queue_cmd(ACT_REMOVE, $urandom, $urandom);
		// Another half-up case, with small rates.
		queue_cmd(ACT_INSERT, 3, 1);
		queue_cmd(ACT_INSERT, 4, 2);
		queue_cmd(ACT_REMOVE, 0, 0);
		queue_cmd(ACT_REMOVE, max_id, max_rate);

		// Random part in chunks of fifty. Each chunk draws its own share of
		// removes, so the queue spends time near empty, near full and in
		// between. Every other chunk waits for the block to drain before its
		// first command goes out.
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n % 50 == 0)
				remove_pct = $urandom_range(15, 70);
			queue_cmd(($urandom_range(0, 99) < remove_pct) ? ACT_REMOVE : ACT_INSERT,
				pick_value(max_id), pick_value(max_rate), (n % 100) == 0);
		end

		// Wait until every command has been transferred and every result has
		// come back, then let the block settle so that it can show anything extra.
		while (cmd_backlog.size() != 0 || issued != accepted || owed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Command driver. A command stays on the bus until the monitor has seen its
	// transfer; only then does the driver idle or present the next one.
	always @(negedge clk) begin
		queue_cmd_t nxt;
		if (!arst_n || (cmd_valid && accepted != issued)) begin
			// Still in reset, or the current command is held.
		end else if (cmd_backlog.size() == 0
				|| (!steady_window && $urandom_range(0, 99) < 6)
				|| (cmd_backlog[0].hold_for_drain && owed_results.size() != 0)) begin
			cmd_valid <= 1'b0;
		end else begin
			nxt        = cmd_backlog.pop_front();
			cmd_valid <= 1'b1;
			action    <= nxt.act;
			item_id   <= nxt.id;
			rate      <= nxt.rt;
			issued++;
		end
	end

	// Result receiver. Stalls come in short runs of random length, which
	// keeps the stalled share of cycles near six in a hundred.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (arst_n && !steady_window && $urandom_range(0, 99) < 3) begin
			stall_left = $urandom_range(0, 2);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Monitor. Both channels are sampled at the rising edge, where inputs have
	// been steady since the falling edge and outputs still hold their values
	// from before the edge. A command transfer updates the ring copy and queues
	// its outcome; a result transfer is checked against the oldest outcome.
	always @(posedge clk) begin
		queue_outcome_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				owed_results.push_back(advance_ring('{action, item_id, rate, 1'b0}));
				accepted++;
			end
			if (res_valid && !res_stall) begin
				if (owed_results.size() == 0) begin
					$error("result transfer with no command outstanding");
					mismatches++;
				end else begin
					want = owed_results.pop_front();
					check_field("mean_rate", want.mean, mean_rate);
					check_field("removed_id", want.rid, removed_id);
					check_field("removed_rate", want.rrate, removed_rate);
					check_field("empty_error", want.err, empty_error);
					check_field("occupancy", want.occ, occupancy);
				end
			end
		end
	end

endmodule
